// File: rtl/swmm_pkg.sv
package swmm_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int FUNC_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int WSIZE_W     = 5;
   localparam int TIMEOUT_W   = 16;

   // item kinds carried on req_tuser
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REDUCE_MODE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic MODE_MEAN   = 1'b0;
   localparam logic MODE_MEDIAN = 1'b1;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                       insert;
      logic                       drain;
      logic signed [SAMPLE_W-1:0] x;
   } cell_ctrl_type;

   // handed from one cell to the next one up
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       gt;
   } cell_link_type;

endpackage

// File: rtl/sample_window_mean_median.sv
// Windowed mean/median reducer. Each req word carries an item kind on tuser (sample, clear
// window, timer tick) and a signed 32-bit sample on tdata. Samples go into a row of
// MAX_WINDOW cells that keeps the window sorted as it fills, while a running sum is kept
// beside it. A sample, clear or tick that emits nothing leaves the block ready for the
// next item. When a window completes (or a tick expires the timeout with samples held),
// the block stops taking items until the result is computed: in mean mode the sum goes
// through a bit-serial divider, one bit per cycle; in median mode the cells shift down
// toward cell 0 and the middle is picked off. A finished result sits in the rsp output
// register while new items are taken; a second result waits for that register to free.
// Registers are written on the csr channel, which is always ready; the user must write
// them only while idle, as the block itself does not enforce it.
module sample_window_mean_median #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // input words
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [swmm_pkg::SAMPLE_W-1:0]      req_tdata,   // [31:0] sample
   input  logic [swmm_pkg::FUNC_W-1:0]        req_tuser,   // [1:0] func
   // result words
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [swmm_pkg::SAMPLE_W-1:0]      rsp_tdata,   // [31:0] reduced_value
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [swmm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [swmm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import swmm_pkg::*;

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_WINDOW);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic [TIMEOUT_W-1:0]       tick_ff, tick_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [WSIZE_W-1:0]         wsize_ff, wsize_in;
   logic                       mode_ff, mode_in;
   logic [TIMEOUT_W-1:0]       timeout_ff, timeout_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [CNT_W-1:0]           k_ff, k_in;
   logic [SAMPLE_W-1:0]        lo_ff, lo_in;
   logic [SAMPLE_W-1:0]        res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic                       is_sample, is_clear, is_tick;
   logic signed [SAMPLE_W-1:0] sample;
   logic signed [SUM_W-1:0]    sample_ext;
   logic                       has_room;
   logic [CNT_W-1:0]           fill_plus;
   logic signed [SUM_W-1:0]    sum_plus;
   logic [TIMEOUT_W-1:0]       tick_plus;
   logic                       tick_hit;
   logic [CNT_W-1:0]           eff_window;
   logic                       emit_sample, emit_tick, emit_go;
   logic [CNT_W-1:0]           emit_n;
   logic signed [SUM_W-1:0]    emit_sum;
   logic [SUM_W-1:0]           emit_mag;
   logic                       div_start, div_done;
   logic [SAMPLE_W-1:0]        div_quotient;
   logic [CNT_W-1:0]           half;
   logic [CNT_W-1:0]           k_plus;
   logic [SAMPLE_W-1:0]        head_value;
   logic [SAMPLE_W:0]          pair_sum;
   logic [SAMPLE_W:0]          pair_adj;
   logic [SAMPLE_W-1:0]        pair_mean;

   cell_ctrl_type              cell_ctrl;
   cell_link_type              links [MAX_WINDOW];

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign is_sample  = accept && (req_tuser == FUNC_SAMPLE);
   assign is_clear   = accept && (req_tuser == FUNC_CLEAR);
   assign is_tick    = accept && (req_tuser == FUNC_TICK);
   assign sample     = $signed(req_tdata);
   assign sample_ext = SUM_W'(sample);

   always_comb begin
      if (wsize_ff == '0) begin
         eff_window = CNT_W'(1);
      end else if (32'(wsize_ff) > 32'(MAX_WINDOW)) begin
         eff_window = MAX_C;
      end else begin
         eff_window = CNT_W'(wsize_ff);
      end
   end

   // a full row drops the word; the window always completes before that
   assign has_room  = fill_ff < MAX_C;
   assign fill_plus = has_room ? CNT_W'(fill_ff + 1'b1) : fill_ff;
   assign sum_plus  = has_room ? SUM_W'(sum_ff + sample_ext) : sum_ff;
   assign tick_plus = TIMEOUT_W'(tick_ff + 1'b1);
   assign tick_hit  = (timeout_ff != '0) && (tick_plus >= timeout_ff);

   assign emit_sample = is_sample && (fill_plus >= eff_window);
   assign emit_tick   = is_tick && tick_hit && (fill_ff != '0);
   assign emit_go     = emit_sample || emit_tick;
   assign emit_n      = emit_sample ? fill_plus : fill_ff;
   assign emit_sum    = emit_sample ? sum_plus : sum_ff;
   assign emit_mag    = emit_sum[SUM_W-1] ? SUM_W'(-emit_sum) : SUM_W'(emit_sum);
   assign div_start   = emit_go && (mode_ff == MODE_MEAN);

   assign cell_ctrl.insert = is_sample && has_room;
   assign cell_ctrl.drain  = state_ff == ST_DRAIN;
   assign cell_ctrl.x      = sample;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      cell_link_type       prev_link;
      logic [SAMPLE_W-1:0] next_value;
      if (i == 0) begin : g_first
         assign prev_link = '0;
      end else begin : g_mid
         assign prev_link = links[i-1];
      end
      if (i == MAX_WINDOW - 1) begin : g_last
         assign next_value = links[i].value;
      end else begin : g_inner
         assign next_value = links[i+1].value;
      end
      swmm_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .fill       (fill_ff),
         .prev_link  (prev_link),
         .next_value (next_value),
         .link       (links[i])
      );
   end

   swmm_div #(
      .SUM_W (SUM_W),
      .DIV_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num_mag  (emit_mag),
      .neg      (emit_sum[SUM_W-1]),
      .divisor  (emit_n),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // median pick: cell 0 shows sorted word k while draining
   assign half       = n_ff >> 1;
   assign k_plus     = CNT_W'(k_ff + 1'b1);
   assign head_value = links[0].value;
   assign pair_sum   = {lo_ff[SAMPLE_W-1], lo_ff} + {head_value[SAMPLE_W-1], head_value};
   // round toward zero before the halving
   assign pair_adj   = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
   assign pair_mean  = pair_adj[SAMPLE_W:1];

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      tick_in      = tick_ff;
      sum_in       = sum_ff;
      wsize_in     = wsize_ff;
      mode_in      = mode_ff;
      timeout_in   = timeout_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (is_sample) begin
         fill_in = fill_plus;
         sum_in  = sum_plus;
      end
      if (is_clear || emit_sample) begin
         fill_in = '0;
         sum_in  = '0;
         tick_in = '0;
      end
      if (is_tick && (timeout_ff != '0)) begin
         if (tick_hit) begin
            tick_in = '0;
            fill_in = '0;
            sum_in  = '0;
         end else begin
            tick_in = tick_plus;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (emit_go) begin
               n_in     = emit_n;
               k_in     = '0;
               state_in = (mode_ff == MODE_MEDIAN) ? ST_DRAIN : ST_DIV;
            end
         end
         ST_DRAIN: begin
            k_in = k_plus;
            if (k_plus == half) begin
               lo_in = head_value;
            end
            if (k_ff == half) begin
               res_in   = n_ff[0] ? head_value : pair_mean;
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = div_quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_SIZE: wsize_in = csr_data[WSIZE_W-1:0];
            CSR_REDUCE_MODE: mode_in  = csr_data[0];
            CSR_TIMEOUT_TICKS: begin
               timeout_in = csr_data[TIMEOUT_W-1:0];
               tick_in    = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         tick_ff      <= '0;
         sum_ff       <= '0;
         wsize_ff     <= WSIZE_W'(1);
         mode_ff      <= MODE_MEAN;
         timeout_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         tick_ff      <= tick_in;
         sum_ff       <= sum_in;
         wsize_ff     <= wsize_in;
         mode_ff      <= mode_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      lo_ff       <= lo_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MAX_C)
      else $error("window fill above row length");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (fill_ff == '0) && (sum_ff == '0))
      else $error("window not emptied after emit");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside mean phase");

   a_median_path: assert property (@(posedge clock) disable iff (reset)
      emit_go && (mode_ff == MODE_MEDIAN) |=> state_ff == ST_DRAIN)
      else $error("median emit did not start draining");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside done phase");

endmodule

// File: rtl/swmm_cell.sv
module swmm_cell #(
   parameter int CNT_W = 5,
   parameter int IDX   = 0
) (
   input  logic                           clock,
   input  swmm_pkg::cell_ctrl_type        ctrl,
   input  logic [CNT_W-1:0]               fill,
   input  swmm_pkg::cell_link_type        prev_link,
   input  logic [swmm_pkg::SAMPLE_W-1:0]  next_value,
   output swmm_pkg::cell_link_type        link
);
   import swmm_pkg::*;

   localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;
   logic                       gt;
   logic                       active;
   logic                       at_end;
   logic signed [SAMPLE_W-1:0] shift_in;

   assign gt       = $signed(value_ff) > $signed(ctrl.x);
   assign active   = IDX_C < fill;
   assign at_end   = IDX_C == fill;
   // take the lower neighbor's word if the new one lands below it, else the new word
   assign shift_in = prev_link.gt ? prev_link.value : ctrl.x;

   always_comb begin
      value_in = value_ff;
      if (ctrl.drain) begin
         value_in = $signed(next_value);
      end else if (ctrl.insert && ((active && gt) || at_end)) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.value = value_ff;
   assign link.gt    = gt;

endmodule

// File: rtl/swmm_div.sv
module swmm_div #(
   parameter int SUM_W = 36,
   parameter int DIV_W = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SUM_W-1:0]               num_mag,
   input  logic                           neg,
   input  logic [DIV_W-1:0]               divisor,
   output logic                           done,
   output logic [swmm_pkg::SAMPLE_W-1:0]  quotient
);
   import swmm_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SUM_W-1:0]    q_ff, q_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    d_ff, d_in;
   logic                neg_ff, neg_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;

   logic [DIV_W:0]      shifted;
   logic [DIV_W:0]      diff;
   logic                fits;
   logic [SUM_W-1:0]    q_next;

   assign shifted = {rem_ff, q_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, d_ff};
   assign diff    = shifted - {1'b0, d_ff};
   assign q_next  = {q_ff[SUM_W-2:0], fits};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         q_in    = num_mag;
         rem_in  = '0;
         d_in    = divisor;
         neg_in  = neg;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         q_in    = q_next;
         rem_in  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? SAMPLE_W'(-q_next[SAMPLE_W-1:0]) : q_next[SAMPLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: verif/sample_window_mean_median_tb.sv
module sample_window_mean_median_tb;
   import swmm_pkg::*;

   localparam int MAX_WINDOW    = 16;
   localparam int SETTLE_CYCLES = 64;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 1600;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      logic [FUNC_W-1:0]      func;
      logic [SAMPLE_W-1:0]    sample;
      bit                     typed;
      logic [SAMPLE_W-1:0]    result;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata;
   logic [FUNC_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [SAMPLE_W-1:0]    rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // shadow of the block's registers and window
   logic [WSIZE_W-1:0]         win_size;
   logic                       win_mode;
   logic [TIMEOUT_W-1:0]       timeout_cfg;
   logic signed [SAMPLE_W-1:0] held [MAX_WINDOW];
   int                         held_count;
   logic [TIMEOUT_W-1:0]       tick_count;

   logic [SAMPLE_W-1:0] expected_values [$];
   logic [SAMPLE_W-1:0] expected_word;
   stim_row_type        directed_rows [$];
   int                  fail_count;
   int                  quiet_cycles;
   int                  req_idle_pct;
   int                  rsp_idle_pct;

   sample_window_mean_median #(.MAX_WINDOW(MAX_WINDOW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                  input logic [SAMPLE_W-1:0] want);
      fail_count++;
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
   endtask

   function automatic logic [SAMPLE_W-1:0] reduce_window();
      logic signed [SAMPLE_W-1:0] sorted [MAX_WINDOW];
      logic signed [SAMPLE_W-1:0] x;
      longint                     sum;
      int                         n;
      int                         i;
      int                         j;
      n = held_count;
      sum = 0;
      if (win_mode == MODE_MEAN) begin
         for (i = 0; i < n; i++)
            sum += longint'(held[i]);
         return SAMPLE_W'(sum / longint'(n));
      end
      for (i = 0; i < n; i++) begin
         x = held[i];
         j = i;
         while (j > 0 && sorted[j-1] > x) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = x;
      end
      if (n % 2 == 1)
         return sorted[n/2];
      // even count: truncated mean of the two middle words
      sum = longint'(sorted[n/2-1]) + longint'(sorted[n/2]);
      return SAMPLE_W'(sum / 2);
   endfunction

   task automatic predict_item(input logic [FUNC_W-1:0] func, input logic [SAMPLE_W-1:0] sample,
                               output bit emits, output logic [SAMPLE_W-1:0] value);
      int limit;
      emits = 1'b0;
      value = '0;
      // saturate the window size into 1..MAX_WINDOW
      limit = (win_size == 0) ? 1 : (win_size > MAX_WINDOW) ? MAX_WINDOW : int'(win_size);
      case (func)
         FUNC_SAMPLE: begin
            if (held_count < MAX_WINDOW) begin
               held[held_count] = sample;
               held_count++;
            end
            if (held_count >= limit) begin
               emits = 1'b1;
               value = reduce_window();
               held_count = 0;
               tick_count = '0;
            end
         end
         FUNC_CLEAR: begin
            held_count = 0;
            tick_count = '0;
         end
         FUNC_TICK: begin
            if (timeout_cfg != 0) begin
               tick_count = tick_count + 1'b1;
               if (tick_count >= timeout_cfg) begin
                  tick_count = '0;
                  if (held_count != 0) begin
                     emits = 1'b1;
                     value = reduce_window();
                  end
                  held_count = 0;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [SAMPLE_W-1:0] sample,
                            input bit typed, input logic [SAMPLE_W-1:0] typed_value);
      bit                  emits;
      logic [SAMPLE_W-1:0] value;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = sample;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_item(func, sample, emits, value);
      if (emits)
         expected_values.push_back(typed ? typed_value : value);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      // drain results, then give the block time to finish any silent item
      while (expected_values.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (index)
         CSR_WINDOW_SIZE: win_size = data[WSIZE_W-1:0];
         CSR_REDUCE_MODE: win_mode = data[0];
         CSR_TIMEOUT_TICKS: begin
            timeout_cfg = data[TIMEOUT_W-1:0];
            tick_count  = '0;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic add_item(input logic [FUNC_W-1:0] func, input logic [SAMPLE_W-1:0] sample,
                           input bit typed, input logic [SAMPLE_W-1:0] result);
      stim_row_type row;
      row = '{ROW_ITEM, CSR_WINDOW_SIZE, '0, func, sample, typed, result};
      directed_rows.push_back(row);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] index,
                          input logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{ROW_CSR, index, data, FUNC_SAMPLE, '0, 1'b0, '0};
      directed_rows.push_back(row);
   endtask

   task automatic run_random(input int items, input int req_pct, input int rsp_pct);
      int                  done;
      int                  seg;
      int                  seg_len;
      int                  pick;
      logic [CSR_DATA_W-1:0] wdata;
      logic [FUNC_W-1:0]   func;
      logic [SAMPLE_W-1:0] sample;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      done = 0;
      while (done < items) begin
         // new settings; any partial window is kept across the change
         case ($urandom_range(9))
            0:       wdata = 1;
            1:       wdata = CSR_DATA_W'(MAX_WINDOW);
            2:       wdata = 0;
            3:       wdata = CSR_DATA_W'($urandom_range(31, MAX_WINDOW + 1));
            default: wdata = CSR_DATA_W'($urandom_range(MAX_WINDOW, 2));
         endcase
         if ($urandom_range(9) < 7)
            write_csr(CSR_WINDOW_SIZE, wdata);
         if ($urandom_range(1))
            write_csr(CSR_REDUCE_MODE,
                      CSR_DATA_W'($urandom_range(1) ? MODE_MEDIAN : MODE_MEAN));
         case ($urandom_range(9))
            0, 1, 2: wdata = 0;
            3:       wdata = 16'hFFFF;
            4:       wdata = CSR_DATA_W'($urandom_range(40, 7));
            default: wdata = CSR_DATA_W'($urandom_range(6, 1));
         endcase
         if ($urandom_range(9) < 6)
            write_csr(CSR_TIMEOUT_TICKS, wdata);

         seg_len = $urandom_range(60, 10);
         seg = 0;
         while (seg < seg_len && done < items) begin
            pick = $urandom_range(99);
            func = (pick < 72) ? FUNC_SAMPLE : (pick < 94) ? FUNC_TICK :
                   (pick < 97) ? FUNC_CLEAR : FUNC_UNUSED;
            case ($urandom_range(9))
               0:       sample = 32'h7FFF_FFFF;
               1:       sample = 32'h8000_0000;
               2:       sample = 32'hFFFF_FFFF;
               3, 4:    sample = $urandom_range(15) - 8;
               default: sample = $urandom;
            endcase
            seg++;
            done++;
            send_item(func, sample, 1'b0, '0);
         end
      end
   endtask

   always @(negedge clock)
      rsp_tready = ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_values.size() == 0) begin
            report_mismatch("result word with none expected", rsp_tdata, 'x);
         end else begin
            expected_word = expected_values.pop_front();
            if (rsp_tdata !== expected_word)
               report_mismatch("reduced_value", rsp_tdata, expected_word);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = FUNC_SAMPLE;
      csr_valid    = 1'b0;
      csr_index    = CSR_WINDOW_SIZE;
      csr_data     = '0;
      req_idle_pct = 12;
      rsp_idle_pct = 55;
      win_size     = 1;
      win_mode     = MODE_MEAN;
      timeout_cfg  = '0;
      held_count   = 0;
      tick_count   = '0;
      for (int i = 0; i < MAX_WINDOW; i++)
         held[i] = '0;

      // after reset: window of one, mean, no timeout
      add_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
      add_item(FUNC_SAMPLE, 32'h8000_0000, 1'b1, 32'h8000_0000);
      add_item(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b0, '0);
      add_item(FUNC_TICK,   32'h0000_0000, 1'b0, '0);
      add_csr(CSR_WINDOW_SIZE, 16'd2);
      add_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF);
      add_item(FUNC_SAMPLE, 32'h8000_0000, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'h8000_0000, 1'b1, 32'h8000_0000);
      // mean rounds toward zero
      add_item(FUNC_SAMPLE, 32'hFFFF_FFFD, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
      add_csr(CSR_REDUCE_MODE, CSR_DATA_W'(MODE_MEDIAN));
      add_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'h8000_0000, 1'b1, 32'h0000_0000);
      add_csr(CSR_WINDOW_SIZE, 16'd0);
      add_item(FUNC_SAMPLE, 32'h0000_0005, 1'b1, 32'h0000_0005);
      add_csr(CSR_WINDOW_SIZE, 16'd31);
      add_csr(CSR_TIMEOUT_TICKS, 16'd3);
      add_item(FUNC_SAMPLE, 32'h0000_0009, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'hFFFF_FFFC, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'h0000_0001, 1'b0, '0);
      add_item(FUNC_TICK,   32'h0000_0000, 1'b0, '0);
      add_item(FUNC_TICK,   32'h0000_0000, 1'b0, '0);
      add_item(FUNC_TICK,   32'h0000_0000, 1'b1, 32'h0000_0001);
      add_item(FUNC_TICK,   32'h0000_0000, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'h0000_0064, 1'b0, '0);
      add_item(FUNC_CLEAR,  32'hFFFF_FFFF, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'h0000_0007, 1'b0, '0);
      add_item(FUNC_SAMPLE, 32'h0000_0008, 1'b0, '0);
      // shrink below the fill level: next word flushes all held samples
      add_csr(CSR_WINDOW_SIZE, 16'd1);
      add_item(FUNC_SAMPLE, 32'h0000_0003, 1'b1, 32'h0000_0007);

      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_CSR)
            write_csr(directed_rows[k].index, directed_rows[k].data);
         else
            send_item(directed_rows[k].func, directed_rows[k].sample,
                      directed_rows[k].typed, directed_rows[k].result);
      end

      run_random(RANDOM_ITEMS / 3, 12, 55);
      run_random(RANDOM_ITEMS / 3, 55, 12);
      run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0);

      while (expected_values.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
